FILE: hdl/m32rseu_pkg.sv
// Shared types, constants and instruction decode for the M32R subset execute unit.
// Depends on nothing; every other file of the unit imports this package.
`timescale 1ns / 1ps

package m32rseu_pkg;

   localparam int MEM_BYTES_DEFAULT = 4096;
   localparam int NUM_REGS = 16;
   localparam int REG_AW = 4;
   localparam int DIV_STEPS = 32;

   localparam logic [REG_AW-1:0] LINK_REG = 4'd14;
   localparam logic [REG_AW-1:0] DONE_REG = 4'd13;
   localparam logic [REG_AW-1:0] ERROR_REG = 4'd12;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_UNKNOWN  = 2'd1,
      STAT_DIV_ZERO = 2'd2,
      STAT_LOADED   = 2'd3
   } status_type;

   typedef struct packed {
      logic        opcode;
      logic [11:0] mem_addr;
      logic [7:0]  mem_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] exec_pc;
      logic [31:0] next_pc;
      logic        cond_bit;
      logic [31:0] done_word;
      logic [31:0] error_word;
   } rsp_type;

   typedef enum logic [6:0] {
      OP_ADD, OP_AND, OP_OR, OP_XOR, OP_SUB, OP_NEG, OP_NOT, OP_MV, OP_MUL,
      OP_CMP, OP_CMPU, OP_CMPI, OP_CMPUI,
      OP_ADD3, OP_AND3, OP_OR3, OP_XOR3, OP_SETH,
      OP_DIV, OP_DIVU, OP_REM, OP_REMU,
      OP_SLL, OP_SRA, OP_SRL, OP_SLL3, OP_SRA3, OP_SRL3,
      OP_LD, OP_LDB, OP_LDUB, OP_LDH, OP_LDUH, OP_LD_PI,
      OP_ST, OP_STB, OP_STH, OP_ST_PI, OP_ST_PD,
      OP_BEQ, OP_BNE, OP_BC, OP_BNC, OP_BRA, OP_BL,
      OP_JL, OP_JMP, OP_BEQZ, OP_BNEZ, OP_BLTZ, OP_BGEZ, OP_BLEZ, OP_BGTZ,
      OP_SRLI, OP_SRAI, OP_SLLI, OP_ADDI, OP_LDI8, OP_LD24, OP_LDI16,
      OP_NOP, OP_BAD
   } op_type;

   typedef enum logic [3:0] {
      CAT_NONE, CAT_CMP, CAT_WRITE, CAT_DIV, CAT_LOAD, CAT_LOAD_PI,
      CAT_STORE, CAT_STORE_UPD, CAT_BAD
   } cat_type;

   typedef enum logic [2:0] {
      MEM_IDLE, MEM_CLEAR, MEM_LOAD, MEM_FETCH, MEM_READ, MEM_WRITE
   } mem_op_type;

   typedef enum logic [2:0] {
      WB_NONE, WB_RES, WB_PTR, WB_LOAD, WB_DIV
   } wb_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOADB, ST_FETCH, ST_DECODE, ST_EXEC, ST_DIV,
      ST_PTR, ST_MEMRD, ST_MEMWR, ST_WB, ST_COMMIT
   } state_type;

   typedef struct packed {
      mem_op_type mem_op;
      logic [1:0] idx;
      logic       acc_shift;
      logic       capture;
      logic       ir_load;
      logic       exec;
      logic       div_start;
      wb_sel_type wb_sel;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic       clear_done;
      cat_type    cat;
      logic [2:0] mem_len;
      logic       div_zero;
      logic       div_done;
   } stat_type;

   // Decode priority follows the encoding groups: register and 32-bit
   // forms first, then displacement branches, then register jumps and zero
   // compares, then immediate shifts, and last immediate adds, loads and NOP.
   function automatic op_type decode_op(input logic [15:0] i1);
      op_type op;
      op = OP_BAD;
      case (i1 & 16'hf0f0)
         16'h00a0: op = OP_ADD;
         16'h00c0: op = OP_AND;
         16'h00e0: op = OP_OR;
         16'h00d0: op = OP_XOR;
         16'h0020: op = OP_SUB;
         16'h0030: op = OP_NEG;
         16'h00b0: op = OP_NOT;
         16'h1080: op = OP_MV;
         16'h1060: op = OP_MUL;
         16'h0040: op = OP_CMP;
         16'h0050: op = OP_CMPU;
         16'h8040: op = OP_CMPI;
         16'h8050: op = OP_CMPUI;
         16'h80a0: op = OP_ADD3;
         16'h80c0: op = OP_AND3;
         16'h80e0: op = OP_OR3;
         16'h80d0: op = OP_XOR3;
         16'hd0c0: op = OP_SETH;
         16'h9000: op = OP_DIV;
         16'h9020: op = OP_REM;
         16'h9010: op = OP_DIVU;
         16'h9030: op = OP_REMU;
         16'h1040: op = OP_SLL;
         16'h1020: op = OP_SRA;
         16'h1000: op = OP_SRL;
         16'h90c0: op = OP_SLL3;
         16'h90a0: op = OP_SRA3;
         16'h9080: op = OP_SRL3;
         16'h20c0: op = OP_LD;
         16'ha0c0: op = OP_LD;
         16'h2080: op = OP_LDB;
         16'ha080: op = OP_LDB;
         16'h2090: op = OP_LDUB;
         16'ha090: op = OP_LDUB;
         16'h20a0: op = OP_LDH;
         16'ha0a0: op = OP_LDH;
         16'h20b0: op = OP_LDUH;
         16'ha0b0: op = OP_LDUH;
         16'h20e0: op = OP_LD_PI;
         16'h2040: op = OP_ST;
         16'ha040: op = OP_ST;
         16'h2060: op = OP_ST_PI;
         16'h2070: op = OP_ST_PD;
         16'h2000: op = OP_STB;
         16'ha000: op = OP_STB;
         16'h2020: op = OP_STH;
         16'ha020: op = OP_STH;
         16'hb000: op = OP_BEQ;
         16'hb010: op = OP_BNE;
         default: op = OP_BAD;
      endcase
      if (op == OP_BAD) begin
         case (i1 & 16'hff00)
            16'h7c00, 16'hfc00: op = OP_BC;
            16'h7d00, 16'hfd00: op = OP_BNC;
            16'h7f00, 16'hff00: op = OP_BRA;
            16'h7e00, 16'hfe00: op = OP_BL;
            default: op = OP_BAD;
         endcase
      end
      if (op == OP_BAD) begin
         case (i1 & 16'hfff0)
            16'h1ec0: op = OP_JL;
            16'h1fc0: op = OP_JMP;
            16'hb080: op = OP_BEQZ;
            16'hb090: op = OP_BNEZ;
            16'hb0a0: op = OP_BLTZ;
            16'hb0b0: op = OP_BGEZ;
            16'hb0c0: op = OP_BLEZ;
            16'hb0d0: op = OP_BGTZ;
            default: op = OP_BAD;
         endcase
      end
      if (op == OP_BAD) begin
         case (i1 & 16'hf0e0)
            16'h5000: op = OP_SRLI;
            16'h5020: op = OP_SRAI;
            16'h5040: op = OP_SLLI;
            default: op = OP_BAD;
         endcase
      end
      if (op == OP_BAD) begin
         if ((i1 & 16'hf000) == 16'h4000) begin
            op = OP_ADDI;
         end else if ((i1 & 16'hf000) == 16'h6000) begin
            op = OP_LDI8;
         end else if ((i1 & 16'hf000) == 16'he000) begin
            op = OP_LD24;
         end else if ((i1 & 16'hf0ff) == 16'h90f0) begin
            op = OP_LDI16;
         end else if (i1 == 16'h7000) begin
            op = OP_NOP;
         end
      end
      return op;
   endfunction

   function automatic cat_type cat_of(input op_type op);
      cat_type cat;
      case (op)
         OP_CMP, OP_CMPU, OP_CMPI, OP_CMPUI: cat = CAT_CMP;
         OP_DIV, OP_DIVU, OP_REM, OP_REMU: cat = CAT_DIV;
         OP_LD, OP_LDB, OP_LDUB, OP_LDH, OP_LDUH: cat = CAT_LOAD;
         OP_LD_PI: cat = CAT_LOAD_PI;
         OP_ST, OP_STB, OP_STH: cat = CAT_STORE;
         OP_ST_PI, OP_ST_PD: cat = CAT_STORE_UPD;
         OP_BEQ, OP_BNE, OP_BC, OP_BNC, OP_BRA, OP_JMP, OP_BEQZ, OP_BNEZ,
         OP_BLTZ, OP_BGEZ, OP_BLEZ, OP_BGTZ, OP_NOP: cat = CAT_NONE;
         OP_BAD: cat = CAT_BAD;
         default: cat = CAT_WRITE;
      endcase
      return cat;
   endfunction

   function automatic logic [2:0] mem_len_of(input op_type op);
      logic [2:0] len;
      case (op)
         OP_LDB, OP_LDUB, OP_STB: len = 3'd1;
         OP_LDH, OP_LDUH, OP_STH: len = 3'd2;
         default: len = 3'd4;
      endcase
      return len;
   endfunction

endpackage

FILE: hdl/m32rseu_div.sv
// Iterative restoring divider for the execute unit, one quotient bit per cycle.
// Depends on m32rseu_pkg for the step count.
`timescale 1ns / 1ps

module m32rseu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   import m32rseu_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] quo_ff;
   logic [31:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [33:0] diff;

   // Bit 33 of the difference is the borrow of the trial subtraction.
   assign diff = {1'b0, rem_ff, quo_ff[31]} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[30:0], ~diff[33]};
         rem_ff <= diff[33] ? {rem_ff[30:0], quo_ff[31]} : diff[31:0];
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/m32rseu_dpath.sv
// Datapath of the execute unit: byte memory, register file, PC, condition bit,
// execute logic and the response register. Depends on m32rseu_pkg and m32rseu_div.
`timescale 1ns / 1ps

module m32rseu_dpath #(
   parameter int MEM_BYTES = m32rseu_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  m32rseu_pkg::req_type  req_data,
   input  m32rseu_pkg::cmd_type  cmd,
   output m32rseu_pkg::stat_type stat,
   output m32rseu_pkg::rsp_type  rsp_data
);
   import m32rseu_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);

   logic [7:0]  mem [MEM_BYTES];
   logic [31:0] rf_mem [NUM_REGS];

   logic [AW-1:0]       clr_ff;
   logic [7:0]          rdata_ff;
   logic [31:0]         acc_ff;
   logic [31:0]         ir_ff;
   logic [31:0]         a_ff;
   logic [31:0]         b_ff;
   logic [31:0]         pc_ff;
   logic                cond_ff;
   logic [NUM_REGS-1:0] rf_valid_ff;
   logic [31:0]         r13_ff;
   logic [31:0]         r12_ff;
   req_type             req_ff;
   rsp_type             rsp_ff;

   logic [31:0]       res_ff, res_in;
   logic [31:0]       npc_ff, npc_in;
   logic [31:0]       ea_ff, ea_in;
   logic [31:0]       ptr_ff, ptr_in;
   logic [31:0]       sd_ff;
   logic [REG_AW-1:0] wreg_ff, wreg_in;
   logic              cond_in;

   op_type      op;
   cat_type     cat;
   logic [2:0]  mem_len;
   logic [15:0] i1;
   logic [15:0] i2;
   logic [REG_AW-1:0] rd;
   logic [REG_AW-1:0] rs;
   logic [31:0] s16, z16, sx8i, d24, seq_pc, disp, br16, brs;

   logic [31:0]   addr_full;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [31:0]   sd_aligned;
   logic [7:0]    st_byte;

   logic              rf_we;
   logic [REG_AW-1:0] rf_waddr;
   logic [31:0]       rf_wdata;
   logic [31:0]       load_val;

   logic        signed_div;
   logic [31:0] dvd_mag, dvs_mag, div_q, div_r, div_val;
   logic        div_done;
   logic [1:0]  stat_code;

   assign i1 = ir_ff[31:16];
   assign i2 = ir_ff[15:0];
   assign rd = i1[11:8];
   assign rs = i1[3:0];
   assign op = decode_op(i1);
   assign cat = cat_of(op);
   assign mem_len = mem_len_of(op);

   assign s16 = {{16{i2[15]}}, i2};
   assign z16 = {16'h0000, i2};
   assign sx8i = {{24{i1[7]}}, i1[7:0]};
   assign d24 = {{8{i1[7]}}, i1[7:0], i2};
   assign seq_pc = pc_ff + (i1[15] ? 32'd4 : 32'd2);
   assign disp = i1[15] ? d24 : sx8i;
   assign br16 = pc_ff + {s16[30:0], 1'b0};
   assign brs = pc_ff + {disp[30:0], 1'b0};

   // Execute: one result, one next PC and one effective address per instruction.
   always_comb begin
      res_in = b_ff;
      wreg_in = rd;
      npc_in = seq_pc;
      cond_in = cond_ff;
      ea_in = i1[15] ? b_ff + s16 : b_ff;
      ptr_in = b_ff + 32'd4;
      case (op)
         OP_ADD:   res_in = a_ff + b_ff;
         OP_AND:   res_in = a_ff & b_ff;
         OP_OR:    res_in = a_ff | b_ff;
         OP_XOR:   res_in = a_ff ^ b_ff;
         OP_SUB:   res_in = a_ff - b_ff;
         OP_NEG:   res_in = 32'd0 - b_ff;
         OP_NOT:   res_in = ~b_ff;
         OP_MV:    res_in = b_ff;
         OP_MUL:   res_in = a_ff * b_ff;
         OP_CMP:   cond_in = $signed(a_ff) < $signed(b_ff);
         OP_CMPU:  cond_in = a_ff < b_ff;
         OP_CMPI:  cond_in = $signed(b_ff) < $signed(s16);
         OP_CMPUI: cond_in = b_ff < s16;
         OP_ADD3:  res_in = b_ff + s16;
         OP_AND3:  res_in = b_ff & z16;
         OP_OR3:   res_in = b_ff | z16;
         OP_XOR3:  res_in = b_ff ^ z16;
         OP_SETH:  res_in = {i2, 16'h0000};
         OP_SLL:   res_in = a_ff << b_ff[4:0];
         OP_SRA:   res_in = $unsigned($signed(a_ff) >>> b_ff[4:0]);
         OP_SRL:   res_in = a_ff >> b_ff[4:0];
         OP_SLL3:  res_in = b_ff << i2[4:0];
         OP_SRA3:  res_in = $unsigned($signed(b_ff) >>> i2[4:0]);
         OP_SRL3:  res_in = b_ff >> i2[4:0];
         OP_SRLI:  res_in = a_ff >> i1[4:0];
         OP_SRAI:  res_in = $unsigned($signed(a_ff) >>> i1[4:0]);
         OP_SLLI:  res_in = a_ff << i1[4:0];
         OP_ADDI:  res_in = a_ff + sx8i;
         OP_LDI8:  res_in = sx8i;
         OP_LD24:  res_in = {8'h00, i1[7:0], i2};
         OP_LDI16: res_in = s16;
         OP_LD_PI: ea_in = b_ff;
         OP_ST_PI: ea_in = b_ff + 32'd4;
         OP_ST_PD: begin
            ea_in = b_ff - 32'd4;
            ptr_in = b_ff - 32'd4;
         end
         // The equal-compare branch targets the word-aligned PC.
         OP_BEQ: begin
            if (a_ff == b_ff) npc_in = {pc_ff[31:2], 2'b00} + {s16[30:0], 1'b0};
         end
         OP_BNE:  if (a_ff != b_ff) npc_in = br16;
         OP_BC:   if (cond_ff) npc_in = brs;
         OP_BNC:  if (!cond_ff) npc_in = brs;
         OP_BRA:  npc_in = brs;
         OP_BL: begin
            res_in = seq_pc;
            wreg_in = LINK_REG;
            npc_in = brs;
         end
         OP_JL: begin
            res_in = seq_pc;
            wreg_in = LINK_REG;
            npc_in = {b_ff[31:1], 1'b0};
         end
         OP_JMP:  npc_in = {b_ff[31:1], 1'b0};
         OP_BEQZ: if (b_ff == 32'd0) npc_in = br16;
         OP_BNEZ: if (b_ff != 32'd0) npc_in = br16;
         OP_BLTZ: if (b_ff[31]) npc_in = br16;
         OP_BGEZ: if (!b_ff[31]) npc_in = br16;
         OP_BLEZ: if (b_ff[31] || b_ff == 32'd0) npc_in = br16;
         OP_BGTZ: if (!b_ff[31] && b_ff != 32'd0) npc_in = br16;
         OP_BAD:  npc_in = pc_ff;
         default: res_in = b_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_ff <= res_in;
         wreg_ff <= wreg_in;
         npc_ff <= npc_in;
         ea_ff <= ea_in;
         ptr_ff <= ptr_in;
         sd_ff <= a_ff;
      end
   end

   // Byte memory: one shared address for the write and the registered read.
   always_comb begin
      case (cmd.mem_op)
         MEM_LOAD:  addr_full = {20'h00000, req_ff.mem_addr};
         MEM_FETCH: addr_full = pc_ff + {30'd0, cmd.idx};
         MEM_READ, MEM_WRITE: addr_full = ea_ff + {30'd0, cmd.idx};
         default:   addr_full = 32'(clr_ff);
      endcase
   end
   assign mem_addr = addr_full[AW-1:0];

   always_comb begin
      case (mem_len)
         3'd1:    sd_aligned = {sd_ff[7:0], 24'h000000};
         3'd2:    sd_aligned = {sd_ff[15:0], 16'h0000};
         default: sd_aligned = sd_ff;
      endcase
      case (cmd.idx)
         2'd0:    st_byte = sd_aligned[31:24];
         2'd1:    st_byte = sd_aligned[23:16];
         2'd2:    st_byte = sd_aligned[15:8];
         default: st_byte = sd_aligned[7:0];
      endcase
      case (cmd.mem_op)
         MEM_LOAD:  mem_wdata = req_ff.mem_byte;
         MEM_WRITE: mem_wdata = st_byte;
         default:   mem_wdata = 8'h00;
      endcase
   end
   assign mem_we = (cmd.mem_op == MEM_CLEAR) || (cmd.mem_op == MEM_LOAD) ||
                   (cmd.mem_op == MEM_WRITE);

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rdata_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.mem_op == MEM_CLEAR) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.acc_shift) acc_ff <= {acc_ff[23:0], rdata_ff};
   end

   // Register file: reads are registered when the instruction is latched.
   always_comb begin
      case (op)
         OP_LDB:  load_val = {{24{acc_ff[7]}}, acc_ff[7:0]};
         OP_LDUB: load_val = {24'h000000, acc_ff[7:0]};
         OP_LDH:  load_val = {{16{acc_ff[15]}}, acc_ff[15:0]};
         OP_LDUH: load_val = {16'h0000, acc_ff[15:0]};
         default: load_val = acc_ff;
      endcase
      case (cmd.wb_sel)
         WB_PTR: begin
            rf_waddr = rs;
            rf_wdata = ptr_ff;
         end
         WB_RES: begin
            rf_waddr = wreg_ff;
            rf_wdata = res_ff;
         end
         WB_DIV: begin
            rf_waddr = rd;
            rf_wdata = div_val;
         end
         default: begin
            rf_waddr = rd;
            rf_wdata = load_val;
         end
      endcase
   end
   assign rf_we = (cmd.wb_sel != WB_NONE);

   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
      if (cmd.ir_load) begin
         ir_ff <= acc_ff;
         a_ff <= rf_valid_ff[acc_ff[27:24]] ? rf_mem[acc_ff[27:24]] : 32'd0;
         b_ff <= rf_valid_ff[acc_ff[19:16]] ? rf_mem[acc_ff[19:16]] : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
         r13_ff <= '0;
         r12_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[rf_waddr] <= 1'b1;
         if (rf_waddr == DONE_REG) r13_ff <= rf_wdata;
         if (rf_waddr == ERROR_REG) r12_ff <= rf_wdata;
      end
   end

   // Divide operands are magnitudes for the signed forms; signs are fixed after.
   assign signed_div = (op == OP_DIV) || (op == OP_REM);
   assign dvd_mag = (signed_div && a_ff[31]) ? 32'd0 - a_ff : a_ff;
   assign dvs_mag = (signed_div && b_ff[31]) ? 32'd0 - b_ff : b_ff;

   m32rseu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd_mag),
      .divisor   (dvs_mag),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      case (op)
         OP_DIV:  div_val = (a_ff[31] ^ b_ff[31]) ? 32'd0 - div_q : div_q;
         OP_REM:  div_val = a_ff[31] ? 32'd0 - div_r : div_r;
         OP_REMU: div_val = div_r;
         default: div_val = div_q;
      endcase
   end

   always_comb begin
      if (!req_ff.opcode) begin
         stat_code = STAT_LOADED;
      end else if (cat == CAT_BAD) begin
         stat_code = STAT_UNKNOWN;
      end else if (cat == CAT_DIV && b_ff == 32'd0) begin
         stat_code = STAT_DIV_ZERO;
      end else begin
         stat_code = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         cond_ff <= 1'b0;
      end else begin
         if (cmd.exec && cat == CAT_CMP) cond_ff <= cond_in;
         if (cmd.commit && req_ff.opcode) pc_ff <= npc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.status <= stat_code;
         rsp_ff.exec_pc <= pc_ff;
         rsp_ff.next_pc <= req_ff.opcode ? npc_ff : pc_ff;
         rsp_ff.cond_bit <= cond_ff;
         rsp_ff.done_word <= r13_ff;
         rsp_ff.error_word <= r12_ff;
      end
   end

   assign rsp_data = rsp_ff;

   assign stat.clear_done = (cmd.mem_op == MEM_CLEAR) && (clr_ff == AW'(MEM_BYTES - 1));
   assign stat.cat = cat;
   assign stat.mem_len = mem_len;
   assign stat.div_zero = (b_ff == 32'd0);
   assign stat.div_done = div_done;

endmodule

FILE: hdl/m32rseu_ctrl.sv
// Sequencing state machine of the execute unit: handshakes and datapath commands.
// Depends on m32rseu_pkg for the state, command and status types.
`timescale 1ns / 1ps

module m32rseu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_opcode,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  m32rseu_pkg::stat_type stat,
   output m32rseu_pkg::cmd_type  cmd
);
   import m32rseu_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (stat.clear_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) state_in = req_opcode ? ST_FETCH : ST_LOADB;
         end
         ST_LOADB:  state_in = ST_COMMIT;
         ST_FETCH:  if (cnt_ff == 3'd4) state_in = ST_DECODE;
         ST_DECODE: state_in = ST_EXEC;
         ST_EXEC: begin
            case (stat.cat)
               CAT_WRITE: state_in = ST_WB;
               CAT_DIV: state_in = stat.div_zero ? ST_COMMIT : ST_DIV;
               CAT_LOAD: state_in = ST_MEMRD;
               CAT_LOAD_PI, CAT_STORE_UPD: state_in = ST_PTR;
               CAT_STORE: state_in = ST_MEMWR;
               default: state_in = ST_COMMIT;
            endcase
         end
         ST_DIV: if (stat.div_done) state_in = ST_WB;
         ST_PTR: state_in = (stat.cat == CAT_LOAD_PI) ? ST_MEMRD : ST_MEMWR;
         ST_MEMRD: if (cnt_ff == stat.mem_len) state_in = ST_WB;
         ST_MEMWR: if (cnt_ff == stat.mem_len - 3'd1) state_in = ST_COMMIT;
         ST_WB: state_in = ST_COMMIT;
         ST_COMMIT: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mem_op = MEM_IDLE;
      cmd.wb_sel = WB_NONE;
      cmd.idx = cnt_ff[1:0];
      case (state_ff)
         ST_CLEAR: cmd.mem_op = MEM_CLEAR;
         ST_IDLE:  cmd.capture = req_valid;
         ST_LOADB: cmd.mem_op = MEM_LOAD;
         ST_FETCH: begin
            if (cnt_ff != 3'd4) cmd.mem_op = MEM_FETCH;
            cmd.acc_shift = (cnt_ff != 3'd0);
         end
         ST_DECODE: cmd.ir_load = 1'b1;
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cmd.div_start = (stat.cat == CAT_DIV) && !stat.div_zero;
         end
         ST_PTR: cmd.wb_sel = WB_PTR;
         ST_MEMRD: begin
            if (cnt_ff < stat.mem_len) cmd.mem_op = MEM_READ;
            cmd.acc_shift = (cnt_ff != 3'd0);
         end
         ST_MEMWR: cmd.mem_op = MEM_WRITE;
         ST_WB: begin
            case (stat.cat)
               CAT_DIV: cmd.wb_sel = WB_DIV;
               CAT_LOAD, CAT_LOAD_PI: cmd.wb_sel = WB_LOAD;
               default: cmd.wb_sel = WB_RES;
            endcase
         end
         ST_COMMIT: cmd.commit = rsp_free;
         default: cmd.mem_op = MEM_IDLE;
      endcase
   end

   assign cnt_in = (state_in != state_ff) ? 3'd0 : cnt_ff + 3'd1;
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   ap_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed transaction did not raise the response valid");
   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("commit overwrote a response that was still waiting");
   ap_div_is_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (stat.cat == CAT_DIV))
      else $error("divider wait entered for a non-divide instruction");
   ap_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response raised during the memory clearing pass");
`endif

endmodule

FILE: hdl/m32r_subset_execute_unit.sv
// M32R subset execute unit, top level: one response transaction per request.
// Throughput: one transaction at a time, paced by the byte-wide memory and bit-serial divider.
// Reset: synchronous; afterwards the memory is cleared to zero before a request is taken.
`timescale 1ns / 1ps

module m32r_subset_execute_unit #(
   parameter int MEM_BYTES = m32rseu_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  m32rseu_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output m32rseu_pkg::rsp_type rsp_data
);
   import m32rseu_pkg::*;

   // MEM_BYTES must be a power of two; byte addresses wrap at that size.
   // The controller sequences each instruction through fetch, decode, execute,
   // divide or memory access, write back and commit; a byte load is stored,
   // then committed. The datapath holds all storage and the response register,
   // so a finished response can wait for the consumer while the controller idles.

   cmd_type  cmd;
   stat_type stat;

   m32rseu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   m32rseu_dpath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
